### sv/sapc_pkg.sv
// Package for the sensor alarm panel controller: payload structs, FSM states,
// register indexes, controller/datapath command struct. No dependencies.
package sapc_pkg;

    typedef struct packed {
        logic               button_left;
        logic               button_right;
        logic [11:0]        pot_raw;
        logic [9:0]         light_level;
        logic signed [11:0] temp_tenths;
        logic [31:0]        now_ms;
        logic               remote_alarm;
        logic signed [11:0] remote_light_x10;
        logic signed [11:0] remote_light_thr_x10;
        logic signed [11:0] remote_temp_x10;
        logic signed [11:0] remote_temp_thr_x10;
    } in_word_t;

    typedef struct packed {
        logic [7:0]         led_pattern;
        logic               buzzer;
        logic [1:0]         mode_now;
        logic               sensor_shown;
        logic [4:0]         clone_id;
        logic               alarm_off_request;
        logic               local_alarm;
        logic signed [11:0] temp_high;
        logic signed [11:0] temp_low;
        logic [9:0]         light_high;
        logic [9:0]         light_low;
    } out_word_t;

    typedef enum logic [1:0] {
        MODE_CONNECTED = 2'd0,
        MODE_CLONE     = 2'd1,
        MODE_TEST      = 2'd2
    } mode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCALE,
        ST_UPDATE,
        ST_DISPLAY,
        ST_OUT
    } state_t;

    localparam logic [1:0] REG_HOLD_TIME  = 2'd0;
    localparam logic [1:0] REG_REARM_TIME = 2'd1;
    localparam logic [1:0] REG_FLASH      = 2'd2;
    localparam logic [1:0] REG_TEMP_FLOOR = 2'd3;

    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 2;

    // Controller -> datapath commands.
    typedef struct packed {
        logic load;
        logic scale;
        logic update;
        logic display;
        logic out_load;
    } dp_cmd_t;

endpackage

### sv/sensor_alarm_panel_controller_core.sv
// Sensor alarm panel controller top level: controller FSM plus datapath.
// Each accepted word passes through the IDLE-SCALE-UPDATE-DISPLAY-OUT sequence; OUT waits
// out any output stall, and a new input word is taken only back in IDLE.
// Reset: rst_n async low clears FSM, mode, alarm, timer and tracker state; loads register defaults.
// Depends on sapc_pkg, sapc_ctrl, sapc_dp.
module sensor_alarm_panel_controller_core
    import sapc_pkg::*;
#(
    parameter int LED_COUNT  = 8,
    parameter int NODE_COUNT = 27
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  in_word_t              in_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output out_word_t             out_data,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    dp_cmd_t cmd;

    sapc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    sapc_dp #(
        .LED_COUNT  (LED_COUNT),
        .NODE_COUNT (NODE_COUNT)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_word   (in_data),
        .cmd       (cmd),
        .out_word  (out_data)
    );

endmodule

### sv/sapc_ctrl.sv
// Controller FSM for the panel controller: sequences load, scale, update, display and output load.
// Depends on sapc_pkg.
module sapc_ctrl
    import sapc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_stall,
    output logic    out_valid,
    input  logic    out_stall,
    output dp_cmd_t cmd
);

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:    if (in_valid) state_next = ST_SCALE;
            ST_SCALE:   state_next = ST_UPDATE;
            ST_UPDATE:  state_next = ST_DISPLAY;
            ST_DISPLAY: state_next = ST_OUT;
            ST_OUT:     if (!out_valid_reg || !out_stall) state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd            = '0;
        in_stall       = 1'b1;
        out_valid_next = out_valid_reg && out_stall;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                cmd.load = in_valid;
            end
            ST_SCALE:   cmd.scale = 1'b1;
            ST_UPDATE:  cmd.update = 1'b1;
            ST_DISPLAY: cmd.display = 1'b1;
            ST_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.scale, cmd.update, cmd.display, cmd.out_load}))
        else $error("more than one datapath command");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");
    a_scale_after_load: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> cmd.scale)
        else $error("scale did not follow load");

endmodule

### sv/sapc_dp.sv
// Datapath of the panel controller: scaling, timers, alarm, trackers, bargraph.
// Depends on sapc_pkg.
module sapc_dp
    import sapc_pkg::*;
#(
    parameter int LED_COUNT  = 8,
    parameter int NODE_COUNT = 27
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  in_word_t              in_word,
    input  dp_cmd_t               cmd,
    output out_word_t             out_word
);

    localparam int LW = $clog2(LED_COUNT + 1);

    // Config
    logic [15:0]        hold_time_reg, rearm_time_reg, flash_period_reg;
    logic signed [10:0] temp_floor_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_time_reg    <= 16'd1000;
            rearm_time_reg   <= 16'd10000;
            flash_period_reg <= 16'd140;
            temp_floor_reg   <= 11'sd250;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_HOLD_TIME:  hold_time_reg    <= cfg_data;
                REG_REARM_TIME: rearm_time_reg   <= cfg_data;
                REG_FLASH:      flash_period_reg <= cfg_data;
                REG_TEMP_FLOOR: temp_floor_reg   <= cfg_data[10:0];
                default: ;
            endcase
        end
    end

    // Input capture
    in_word_t in_reg;
    always_ff @(posedge clk)
    begin
        if (cmd.load)
            in_reg <= in_word;
    end

    // Temperature to bargraph scale: (t - floor) * 20, clamped to 0..1000
    function automatic logic [9:0] temp_bar(input logic signed [11:0] t,
                                            input logic signed [10:0] fl);
        logic signed [13:0] d;
        logic signed [19:0] p;
        begin
            d = 14'(t) - 14'(fl);
            p = 20'(d) * 20'sd20;
            if (d <= 0)
                temp_bar = 10'd0;
            else if (p > 20'sd1000)
                temp_bar = 10'd1000;
            else
                temp_bar = p[9:0];
        end
    endfunction

    function automatic logic [9:0] clamp1000(input logic signed [11:0] v);
        begin
            if (v < 0)
                clamp1000 = 10'd0;
            else if (v > 12'sd1000)
                clamp1000 = 10'd1000;
            else
                clamp1000 = v[9:0];
        end
    endfunction

    // Scale stage: pot level in tenths of a percent = pot*1000/4095 via reciprocal and correction
    logic [9:0]  pot_reg, light_reg, ntc_reg;
    logic [21:0] pot_prod;
    logic [9:0]  pot_q;
    logic [21:0] pot_rem;
    always_comb
    begin
        pot_prod = 22'(in_reg.pot_raw) * 22'd1000;
        // floor(x/4095) = (x + (x>>12) + 1) >> 12 for x < 2^24
        pot_q    = 10'((pot_prod + (pot_prod >> 12) + 22'd1) >> 12);
        pot_rem  = pot_prod - 22'(pot_q) * 22'd4095;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.scale)
        begin
            pot_reg   <= (pot_rem >= 22'd4095) ? pot_q + 10'd1 : pot_q;
            light_reg <= (in_reg.light_level > 10'd1000) ? 10'd1000
                                                         : in_reg.light_level;
            ntc_reg   <= temp_bar(in_reg.temp_tenths, temp_floor_reg);
        end
    end

    // Clone id: pct*NODE_COUNT/1001, capped; found by comparing the product
    // against multiples of 1001, the last one reached gives the id
    localparam int CW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
    logic [17:0]   id_prod;
    logic [CW-1:0] id_c;
    always_comb
    begin
        id_prod = 18'(pot_reg) * 18'(NODE_COUNT);
        id_c    = '0;
        for (int i = 1; i < NODE_COUNT; i++)
            if (id_prod >= 18'(i * 1001))
                id_c = CW'(i);
    end

    // State
    logic        left_prev_reg, right_prev_reg, hold_counting_reg;
    logic [31:0] hold_start_reg, mute_start_reg, disarm_start_reg, flash_start_reg;
    mode_t       mode_reg;
    logic        sensor_select_reg, clone_muted_reg, alarm_latched_reg;
    logic        alarm_disarmed_reg, flash_on_reg, off_req_reg;
    logic [CW-1:0] clone_target_reg;
    logic signed [11:0] temp_max_reg, temp_min_reg;
    logic [9:0]  light_max_reg, light_min_reg;

    // Update stage combinational next values
    logic        hold_counting_next, sensor_select_next, clone_muted_next;
    logic        alarm_latched_next, alarm_disarmed_next, off_req_next;
    logic [31:0] hold_start_next, mute_start_next, disarm_start_next;
    mode_t       mode_next;
    logic [CW-1:0] clone_target_next;
    logic        bl, br;
    logic [31:0] now;

    always_comb
    begin
        bl = in_reg.button_left;
        br = in_reg.button_right;
        now = in_reg.now_ms;
        hold_counting_next  = hold_counting_reg;
        hold_start_next     = hold_start_reg;
        mode_next           = mode_reg;
        sensor_select_next  = sensor_select_reg;
        clone_muted_next    = clone_muted_reg;
        mute_start_next     = mute_start_reg;
        alarm_latched_next  = alarm_latched_reg;
        alarm_disarmed_next = alarm_disarmed_reg;
        disarm_start_next   = disarm_start_reg;
        off_req_next        = 1'b0;
        clone_target_next   = clone_target_reg;

        if (mode_reg == MODE_CLONE)
            clone_target_next = id_c;

        if (bl && br)
        begin
            if (!hold_counting_reg)
            begin
                hold_counting_next = 1'b1;
                hold_start_next    = now;
            end
            else if ((now - hold_start_reg) >= 32'(hold_time_reg))
            begin
                case (mode_reg)
                    MODE_CONNECTED: mode_next = MODE_CLONE;
                    MODE_CLONE:     mode_next = MODE_TEST;
                    default:        mode_next = MODE_CONNECTED;
                endcase
                hold_counting_next = 1'b0;
            end
        end
        else
        begin
            hold_counting_next = 1'b0;
            if (bl && !left_prev_reg)
                sensor_select_next = !sensor_select_reg;
            if (br && !right_prev_reg)
            begin
                if (mode_reg == MODE_CLONE)
                begin
                    if (in_reg.remote_alarm)
                    begin
                        off_req_next     = 1'b1;
                        clone_muted_next = 1'b1;
                        mute_start_next  = now;
                    end
                end
                else if (alarm_latched_reg)
                begin
                    alarm_latched_next  = 1'b0;
                    alarm_disarmed_next = 1'b1;
                    disarm_start_next   = now;
                end
            end
        end

        if (alarm_disarmed_next && (now - disarm_start_next) >= 32'(rearm_time_reg))
            alarm_disarmed_next = 1'b0;
        if (clone_muted_next && (now - mute_start_next) >= 32'(rearm_time_reg))
            clone_muted_next = 1'b0;

        if (mode_next == MODE_CONNECTED && !alarm_latched_next && !alarm_disarmed_next
            && (light_reg > pot_reg || ntc_reg > pot_reg))
            alarm_latched_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_prev_reg      <= 1'b0;
            right_prev_reg     <= 1'b0;
            hold_counting_reg  <= 1'b0;
            hold_start_reg     <= '0;
            mode_reg           <= MODE_CONNECTED;
            sensor_select_reg  <= 1'b0;
            clone_target_reg   <= '0;
            clone_muted_reg    <= 1'b0;
            mute_start_reg     <= '0;
            alarm_latched_reg  <= 1'b0;
            alarm_disarmed_reg <= 1'b0;
            disarm_start_reg   <= '0;
            off_req_reg        <= 1'b0;
            temp_max_reg       <= -12'sd2048;
            temp_min_reg       <= 12'sd2047;
            light_max_reg      <= 10'd0;
            light_min_reg      <= 10'd1000;
        end
        else if (cmd.update)
        begin
            left_prev_reg      <= bl;
            right_prev_reg     <= br;
            hold_counting_reg  <= hold_counting_next;
            hold_start_reg     <= hold_start_next;
            mode_reg           <= mode_next;
            sensor_select_reg  <= sensor_select_next;
            clone_target_reg   <= clone_target_next;
            clone_muted_reg    <= clone_muted_next;
            mute_start_reg     <= mute_start_next;
            alarm_latched_reg  <= alarm_latched_next;
            alarm_disarmed_reg <= alarm_disarmed_next;
            disarm_start_reg   <= disarm_start_next;
            off_req_reg        <= off_req_next;
            if (in_reg.temp_tenths > temp_max_reg) temp_max_reg <= in_reg.temp_tenths;
            if (in_reg.temp_tenths < temp_min_reg) temp_min_reg <= in_reg.temp_tenths;
            if (light_reg > light_max_reg) light_max_reg <= light_reg;
            if (light_reg < light_min_reg) light_min_reg <= light_reg;
        end
    end

    // Display stage: choose display/level, flash, buzzer
    logic [9:0] disp_c, level_c;
    logic       buzz_c;
    always_comb
    begin
        if (mode_reg == MODE_CLONE)
        begin
            if (!sensor_select_reg)
            begin
                disp_c  = clamp1000(in_reg.remote_light_x10);
                level_c = clamp1000(in_reg.remote_light_thr_x10);
            end
            else
            begin
                disp_c  = temp_bar(in_reg.remote_temp_x10, temp_floor_reg);
                level_c = clamp1000(in_reg.remote_temp_thr_x10);
            end
            buzz_c = in_reg.remote_alarm && !clone_muted_reg;
        end
        else
        begin
            disp_c  = sensor_select_reg ? ntc_reg : light_reg;
            level_c = pot_reg;
            buzz_c  = alarm_latched_reg;
        end
    end

    logic [9:0] disp_reg, level_reg;
    logic       buzz_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flash_on_reg    <= 1'b0;
            flash_start_reg <= '0;
        end
        else if (cmd.display && (in_reg.now_ms - flash_start_reg) >= 32'(flash_period_reg))
        begin
            flash_on_reg    <= !flash_on_reg;
            flash_start_reg <= in_reg.now_ms;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.display)
        begin
            disp_reg  <= disp_c;
            level_reg <= level_c;
            buzz_reg  <= buzz_c;
        end
    end

    // Bargraph: lit count and threshold LED from compares against multiples
    // of 1000; display and level never exceed 1000, so both stay in range
    localparam int PW = (LED_COUNT > 8) ? LED_COUNT : 8;
    logic [15:0]   disp_scaled, level_scaled;
    logic [LW-1:0] num_c, aled_c;
    logic [PW-1:0] pat_c;
    always_comb
    begin
        disp_scaled  = 16'(disp_reg) * 16'(LED_COUNT);
        level_scaled = 16'(level_reg) * 16'(LED_COUNT - 1);
        num_c        = '0;
        aled_c       = '0;
        for (int i = 1; i <= LED_COUNT; i++)
            if (disp_scaled >= 16'(i * 1000))
                num_c = LW'(i);
        for (int i = 1; i < LED_COUNT; i++)
            if (level_scaled >= 16'(i * 1000))
                aled_c = LW'(i);
        pat_c = '0;
        for (int i = 0; i < LED_COUNT; i++)
            if (32'(i) < 32'(num_c))
                pat_c[i] = 1'b1;
        for (int i = 0; i < LED_COUNT; i++)
            if (LW'(i) == aled_c)
                pat_c[i] = flash_on_reg;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_word.led_pattern       <= pat_c[7:0];
            out_word.buzzer            <= buzz_reg;
            out_word.mode_now          <= mode_reg;
            out_word.sensor_shown      <= sensor_select_reg;
            out_word.clone_id          <= 5'(clone_target_reg);
            out_word.alarm_off_request <= off_req_reg;
            out_word.local_alarm       <= alarm_latched_reg;
            out_word.temp_high         <= temp_max_reg;
            out_word.temp_low          <= temp_min_reg;
            out_word.light_high        <= light_max_reg;
            out_word.light_low         <= light_min_reg;
        end
    end

    a_alarm_only_connected: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.update && !alarm_latched_reg && mode_next != MODE_CONNECTED
        |=> !alarm_latched_reg)
        else $error("alarm latched outside connected mode");
    a_disarm_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        alarm_disarmed_reg |-> !alarm_latched_reg)
        else $error("alarm latched while disarmed");
    a_offreq_clone: assert property (@(posedge clk) disable iff (!rst_n)
        off_req_reg |-> mode_reg == MODE_CLONE)
        else $error("off request outside clone mode");

endmodule
